// ===== src/psm_pkg.sv =====
// ----------------------------------------------------------------------------
// PL/0 p-code stack machine package
// Shared widths, opcode and operation codes, fault codes and control types.
// ----------------------------------------------------------------------------
`default_nettype none

package psm_pkg;

    localparam int STACK_DEPTH = 512;
    localparam int MAX_LEVEL   = 3;
    localparam int CODE_SIZE   = 2048;

    localparam int SAW = $clog2(STACK_DEPTH);
    localparam int PCW = $clog2(CODE_SIZE);
    localparam int DW  = 32;
    localparam int AW  = 34;

    typedef enum logic [2:0] {
        K_LIT = 3'd0,
        K_OPR = 3'd1,
        K_LOD = 3'd2,
        K_STO = 3'd3,
        K_CAL = 3'd4,
        K_INT = 3'd5,
        K_JMP = 3'd6,
        K_JPC = 3'd7
    } t_kind;

    localparam logic [10:0] OP_RET = 11'd0;
    localparam logic [10:0] OP_NEG = 11'd1;
    localparam logic [10:0] OP_ADD = 11'd2;
    localparam logic [10:0] OP_SUB = 11'd3;
    localparam logic [10:0] OP_MUL = 11'd4;
    localparam logic [10:0] OP_DIV = 11'd5;
    localparam logic [10:0] OP_ODD = 11'd6;
    localparam logic [10:0] OP_EQL = 11'd8;
    localparam logic [10:0] OP_NEQ = 11'd9;
    localparam logic [10:0] OP_LSS = 11'd10;
    localparam logic [10:0] OP_LEQ = 11'd11;
    localparam logic [10:0] OP_GTR = 11'd12;
    localparam logic [10:0] OP_GEQ = 11'd13;

    localparam logic [1:0] F_NONE  = 2'd0;
    localparam logic [1:0] F_DIV0  = 2'd1;
    localparam logic [1:0] F_RANGE = 2'd2;

    typedef struct packed {
        logic          start;
        logic [DW-1:0] dividend;
        logic [DW-1:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic          done;
        logic [DW-1:0] quotient;
    } t_div_rsp;

endpackage

`default_nettype wire

// ===== src/psm_if.sv =====
// ----------------------------------------------------------------------------
// Valid/ready channel interface
// Carries one handshake and its payload fields between a source and a sink.
// ----------------------------------------------------------------------------
`default_nettype none

interface psm_in_if;
    logic        valid;
    logic        ready;
    logic [2:0]  kind;
    logic [1:0]  level;
    logic [10:0] argument;
    modport source (output valid, kind, level, argument, input ready);
    modport sink (input valid, kind, level, argument, output ready);
endinterface

interface psm_out_if;
    logic               valid;
    logic               ready;
    logic [10:0]        next_pc;
    logic [8:0]         top_index;
    logic [8:0]         base_index;
    logic signed [31:0] top_value;
    logic               halted;
    logic [1:0]         fault;
    modport source (output valid, next_pc, top_index, base_index, top_value, halted, fault,
                    input ready);
    modport sink (input valid, next_pc, top_index, base_index, top_value, halted, fault,
                  output ready);
endinterface

`default_nettype wire

// ===== src/psm_ram.sv =====
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or one read per cycle; the read data is registered.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 512
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        o_rdata <= r_mem[i_addr];
    end

endmodule

`default_nettype wire

// ===== src/psm_div.sv =====
// ----------------------------------------------------------------------------
// Iterative signed divider
// Restoring division, one quotient bit per cycle, truncating toward zero.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire psm_pkg::t_div_req i_req,
    output psm_pkg::t_div_rsp      o_rsp
);

    logic                        r_busy, n_busy;
    logic [5:0]                  r_cnt, n_cnt;
    logic [psm_pkg::DW-1:0]      r_quo, n_quo;
    logic [psm_pkg::DW-1:0]      r_rem, n_rem;
    logic [psm_pkg::DW-1:0]      r_den, n_den;
    logic                        r_neg, n_neg;
    logic                        r_done, n_done;
    logic [psm_pkg::DW:0]        w_trial;
    logic [psm_pkg::DW-1:0]      w_shift;

    always_comb begin
        n_busy = r_busy;
        n_cnt  = r_cnt;
        n_quo  = r_quo;
        n_rem  = r_rem;
        n_den  = r_den;
        n_neg  = r_neg;
        n_done = 1'b0;
        w_shift = {r_rem[psm_pkg::DW-2:0], r_quo[psm_pkg::DW-1]};
        w_trial = {1'b0, w_shift} - {1'b0, r_den};
        if (i_req.start) begin
            n_busy = 1'b1;
            n_cnt  = 6'd0;
            n_rem  = '0;
            n_quo  = i_req.dividend[psm_pkg::DW-1] ? (~i_req.dividend + 1'b1) : i_req.dividend;
            n_den  = i_req.divisor[psm_pkg::DW-1] ? (~i_req.divisor + 1'b1) : i_req.divisor;
            n_neg  = i_req.dividend[psm_pkg::DW-1] ^ i_req.divisor[psm_pkg::DW-1];
        end else if (r_busy) begin
            if ((r_rem[psm_pkg::DW-1] == 1'b0) && !w_trial[psm_pkg::DW]) begin
                n_rem = w_trial[psm_pkg::DW-1:0];
                n_quo = {r_quo[psm_pkg::DW-2:0], 1'b1};
            end else if (r_rem[psm_pkg::DW-1]) begin
                n_rem = w_shift - r_den;
                n_quo = {r_quo[psm_pkg::DW-2:0], 1'b1};
            end else begin
                n_rem = w_shift;
                n_quo = {r_quo[psm_pkg::DW-2:0], 1'b0};
            end
            n_cnt = r_cnt + 6'd1;
            if (r_cnt == 6'(psm_pkg::DW - 1)) begin
                n_busy = 1'b0;
                n_done = 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_busy <= n_busy;
            r_done <= n_done;
        end
        r_cnt <= n_cnt;
        r_quo <= n_quo;
        r_rem <= n_rem;
        r_den <= n_den;
        r_neg <= n_neg;
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_neg ? (~r_quo + 1'b1) : r_quo;

endmodule

`default_nettype wire

// ===== src/pcode_stack_machine_step.sv =====
// All stack reads and writes go through the single stack RAM port (one read or write per
// cycle), and a load, store or call first walks up to three static links.
// Divide runs in the one-bit-per-cycle divider.
// One instruction at a time; the next is taken only after the result is transferred
// and the block is back in its idle state.
// After reset a clearing pass zeroes all 512 stack cells before the first transfer.
`default_nettype none

module pcode_stack_machine_step (
    input wire logic     i_clk,
    input wire logic     i_rst_n,
    psm_in_if.sink       i_in,
    psm_out_if.source    o_out
);

    typedef enum logic [9:0] {
        S_CLR   = 10'b0000000001,
        S_IDLE  = 10'b0000000010,
        S_WALK  = 10'b0000000100,
        S_RD    = 10'b0000001000,
        S_RWAIT = 10'b0000010000,
        S_EXEC  = 10'b0000100000,
        S_DIV   = 10'b0001000000,
        S_WR    = 10'b0010000000,
        S_TOP   = 10'b0100000000,
        S_OUT   = 10'b1000000000
    } t_state;

    localparam int SAW = psm_pkg::SAW;
    localparam int AW  = psm_pkg::AW;
    localparam int DW  = psm_pkg::DW;

    t_state                r_st, n_st;
    logic [SAW:0]          r_clr;
    logic [2:0]            r_kind;
    logic [10:0]           r_arg;
    logic [psm_pkg::PCW-1:0] r_pc, r_np;
    logic [SAW-1:0]        r_b, r_t;
    logic signed [AW-1:0]  r_tn, r_bn, r_link;
    logic [1:0]            r_cnt;
    logic [1:0]            r_phase;
    logic signed [AW-1:0]  r_ra;
    logic [DW-1:0]         r_x, r_y;
    logic [DW-1:0]         r_res;
    logic [1:0]            r_fault;
    logic                  r_ovalid;
    logic [DW-1:0]         r_otop;

    logic                  w_we;
    logic [SAW-1:0]        w_addr;
    logic [DW-1:0]         w_wdata, w_rdata;
    psm_pkg::t_div_req     w_dreq;
    psm_pkg::t_div_rsp     w_drsp;

    function automatic logic in_rng(input logic signed [AW-1:0] a);
        return (a >= 0) && (a < AW'(psm_pkg::STACK_DEPTH));
    endfunction

    function automatic logic signed [AW-1:0] sx(input logic [DW-1:0] v);
        return AW'(signed'(v));
    endfunction

    // Read plan: list of (address) reads needed after the walk.
    logic signed [AW-1:0]  w_rd_addr;
    logic                  w_need_rd;
    logic                  w_two;
    logic signed [AW-1:0]  w_wr_addr;
    logic [DW-1:0]         w_wr_val;
    logic                  w_do_wr;
    logic signed [AW-1:0]  w_sa;

    psm_ram #(.WIDTH(DW), .DEPTH(psm_pkg::STACK_DEPTH)) u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_addr (w_addr),
        .i_wdata(w_wdata),
        .o_rdata(w_rdata)
    );

    psm_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    logic r_opr_bin, r_opr_un, r_opr_ret;

    always_comb begin
        w_sa = '0;
        w_need_rd = 1'b0;
        w_two = 1'b0;
        case (r_kind)
            psm_pkg::K_OPR: begin
                if (r_opr_ret) begin
                    w_need_rd = 1'b1; w_two = 1'b1;
                    w_sa = (r_phase == 2'd0) ? AW'(r_b) + 2 : AW'(r_b) + 1;
                end else if (r_opr_bin) begin
                    w_need_rd = 1'b1; w_two = 1'b1;
                    w_sa = (r_phase == 2'd0) ? AW'(r_t) - 1 : AW'(r_t);
                end else if (r_opr_un) begin
                    w_need_rd = 1'b1;
                    w_sa = AW'(r_t);
                end
            end
            psm_pkg::K_LOD: begin
                w_need_rd = 1'b1;
                w_sa = r_link + AW'(r_arg);
            end
            psm_pkg::K_STO, psm_pkg::K_JPC: begin
                w_need_rd = 1'b1;
                w_sa = AW'(r_t);
            end
            default: ;
        endcase
        w_rd_addr = w_sa;
    end

    always_comb begin
        w_wr_addr = '0;
        w_wr_val  = r_res;
        w_do_wr   = 1'b0;
        case (r_kind)
            psm_pkg::K_LIT: begin
                w_do_wr = 1'b1; w_wr_addr = AW'(r_t) + 1; w_wr_val = DW'(r_arg);
            end
            psm_pkg::K_OPR: begin
                w_do_wr = r_opr_bin | r_opr_un;
                w_wr_addr = r_opr_bin ? AW'(r_t) - 1 : AW'(r_t);
            end
            psm_pkg::K_LOD: begin
                w_do_wr = 1'b1; w_wr_addr = AW'(r_t) + 1; w_wr_val = r_x;
            end
            psm_pkg::K_STO: begin
                w_do_wr = 1'b1; w_wr_addr = r_link + AW'(r_arg); w_wr_val = r_x;
            end
            psm_pkg::K_CAL: begin
                w_do_wr = 1'b1;
                w_wr_addr = AW'(r_t) + 1 + AW'(r_phase);
                w_wr_val = (r_phase == 2'd0) ? DW'(r_link) :
                           (r_phase == 2'd1) ? DW'(r_b) : DW'(r_np);
            end
            default: ;
        endcase
    end

    always_comb begin
        w_we    = 1'b0;
        w_addr  = r_t;
        w_wdata = w_wr_val;
        w_dreq.start    = 1'b0;
        w_dreq.dividend = r_x;
        w_dreq.divisor  = r_y;
        case (r_st)
            S_CLR: begin
                w_we = 1'b1; w_addr = r_clr[SAW-1:0]; w_wdata = '0;
            end
            S_WALK: w_addr = r_link[SAW-1:0];
            S_RD:   w_addr = w_rd_addr[SAW-1:0];
            S_WR: begin
                w_addr = w_wr_addr[SAW-1:0];
                w_we = w_do_wr && in_rng(w_wr_addr);
            end
            S_TOP: w_addr = r_tn[SAW-1:0];
            S_EXEC: w_dreq.start = (r_kind == psm_pkg::K_OPR) && r_opr_bin &&
                                   (r_arg == psm_pkg::OP_DIV) && (r_y != '0);
            default: ;
        endcase
    end

    logic signed [DW-1:0] w_xs, w_ys;
    logic [2*DW-1:0] w_prod;
    assign w_xs = signed'(r_x);
    assign w_ys = signed'(r_y);
    assign w_prod = r_x * r_y;

    always_comb begin
        n_st = r_st;
        case (r_st)
            S_CLR:   if (r_clr == (SAW+1)'(psm_pkg::STACK_DEPTH - 1)) n_st = S_IDLE;
            S_IDLE:  if (i_in.valid) n_st = S_WALK;
            default: n_st = r_st;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st     <= S_CLR;
            r_clr    <= '0;
            r_pc     <= '0;
            r_b      <= SAW'(1);
            r_t      <= '0;
            r_ovalid <= 1'b0;
        end else begin
            case (r_st)
                S_CLR: begin
                    r_clr <= r_clr + 1'b1;
                    r_st  <= n_st;
                end
                S_IDLE: begin
                    if (i_in.valid) begin
                        r_kind  <= i_in.kind;
                        r_arg   <= i_in.argument;
                        r_link  <= AW'(r_b);
                        r_cnt   <= i_in.level;
                        r_np    <= r_pc + 1'b1;
                        r_fault <= psm_pkg::F_NONE;
                        r_phase <= '0;
                        r_tn    <= AW'(r_t);
                        r_bn    <= AW'(r_b);
                        r_opr_ret <= i_in.argument == psm_pkg::OP_RET;
                        r_opr_un  <= (i_in.argument == psm_pkg::OP_NEG) ||
                                     (i_in.argument == psm_pkg::OP_ODD);
                        r_opr_bin <= (i_in.argument inside {[11'd2:11'd5], [11'd8:11'd13]});
                        r_st <= S_WALK;
                    end
                end
                S_WALK: begin
                    if ((r_kind == psm_pkg::K_LOD || r_kind == psm_pkg::K_STO ||
                         r_kind == psm_pkg::K_CAL) && r_cnt != 2'd0) begin
                        if (!in_rng(r_link)) begin
                            r_fault <= psm_pkg::F_RANGE;
                            r_link  <= '0;
                            r_cnt   <= r_cnt - 1'b1;
                        end else begin
                            r_st <= S_RWAIT;
                            r_phase <= 2'd3;
                        end
                    end else begin
                        r_st <= S_RD;
                    end
                end
                S_RWAIT: begin
                    r_link <= sx(w_rdata);
                    r_cnt  <= r_cnt - 1'b1;
                    r_phase <= '0;
                    r_st   <= S_WALK;
                end
                S_RD: begin
                    if (w_need_rd) begin
                        if (!in_rng(w_rd_addr)) r_fault <= psm_pkg::F_RANGE;
                        r_ra <= w_rd_addr;
                        r_st <= S_TOP;
                        r_cnt <= 2'd1;
                    end else begin
                        r_st <= S_EXEC;
                    end
                end
                S_TOP: begin
                    if (r_cnt == 2'd1) begin
                        // Read data of the operand fetch arrives now.
                        if (r_phase == 2'd0) r_x <= in_rng(r_ra) ? w_rdata : '0;
                        else                 r_y <= in_rng(r_ra) ? w_rdata : '0;
                        if (w_two && r_phase == 2'd0) begin
                            r_phase <= 2'd1;
                            r_st <= S_RD;
                        end else begin
                            r_phase <= '0;
                            r_st <= S_EXEC;
                        end
                        r_cnt <= '0;
                    end else if (r_cnt == 2'd2) begin
                        r_cnt <= 2'd3;
                    end else begin
                        r_otop <= w_rdata;
                        r_st <= S_OUT;
                        r_ovalid <= 1'b1;
                    end
                end
                S_EXEC: begin
                    if (r_kind == psm_pkg::K_OPR && r_opr_bin &&
                        r_arg == psm_pkg::OP_DIV && r_y != '0) begin
                        r_st <= S_DIV;
                    end else begin
                        r_st <= S_WR;
                    end
                    case (r_kind)
                        psm_pkg::K_LIT, psm_pkg::K_LOD: r_tn <= AW'(r_t) + 1;
                        psm_pkg::K_STO: r_tn <= AW'(r_t) - 1;
                        psm_pkg::K_INT: r_tn <= AW'(r_t) + AW'(r_arg);
                        psm_pkg::K_JMP: r_np <= r_arg[psm_pkg::PCW-1:0];
                        psm_pkg::K_JPC: begin
                            if (r_x == '0) r_np <= r_arg[psm_pkg::PCW-1:0];
                            r_tn <= AW'(r_t) - 1;
                        end
                        psm_pkg::K_CAL: r_bn <= AW'(r_t) + 1;
                        psm_pkg::K_OPR: begin
                            if (r_opr_ret) begin
                                r_tn <= AW'(r_b) - 1;
                                r_np <= r_x[psm_pkg::PCW-1:0];
                                r_bn <= sx(r_y);
                            end else if (r_opr_un) begin
                                r_res <= (r_arg == psm_pkg::OP_NEG) ? (32'd0 - r_x) :
                                         (r_x[0] ? (r_x[DW-1] ? '1 : 32'd1) : '0);
                            end else if (r_opr_bin) begin
                                r_tn <= AW'(r_t) - 1;
                                case (r_arg)
                                    psm_pkg::OP_ADD: r_res <= r_x + r_y;
                                    psm_pkg::OP_SUB: r_res <= r_x - r_y;
                                    psm_pkg::OP_MUL: r_res <= w_prod[DW-1:0];
                                    psm_pkg::OP_DIV: begin
                                        r_res <= '0;
                                        if (r_y == '0 && r_fault == psm_pkg::F_NONE)
                                            r_fault <= psm_pkg::F_DIV0;
                                    end
                                    psm_pkg::OP_EQL: r_res <= DW'(w_xs == w_ys);
                                    psm_pkg::OP_NEQ: r_res <= DW'(w_xs != w_ys);
                                    psm_pkg::OP_LSS: r_res <= DW'(w_xs < w_ys);
                                    psm_pkg::OP_LEQ: r_res <= DW'(w_xs <= w_ys);
                                    psm_pkg::OP_GTR: r_res <= DW'(w_xs > w_ys);
                                    default:         r_res <= DW'(w_xs >= w_ys);
                                endcase
                            end
                        end
                        default: ;
                    endcase
                end
                S_DIV: begin
                    if (w_drsp.done) begin
                        r_res <= w_drsp.quotient;
                        r_st  <= S_WR;
                    end
                end
                S_WR: begin
                    if (r_kind == psm_pkg::K_CAL && r_phase != 2'd2) begin
                        if (w_do_wr && !in_rng(w_wr_addr)) r_fault <= psm_pkg::F_RANGE;
                        r_phase <= r_phase + 1'b1;
                    end else begin
                        if ((w_do_wr && !in_rng(w_wr_addr)) || !in_rng(r_tn) ||
                            !in_rng(r_bn)) begin
                            r_fault <= psm_pkg::F_RANGE;
                        end
                        r_t  <= r_tn[SAW-1:0];
                        r_b  <= r_bn[SAW-1:0];
                        r_pc <= (r_kind == psm_pkg::K_CAL) ? r_arg[psm_pkg::PCW-1:0] : r_np;
                        r_cnt <= 2'd2;
                        r_phase <= '0;
                        r_st <= S_TOP;
                    end
                end
                S_OUT: begin
                    if (o_out.ready) begin
                        r_ovalid <= 1'b0;
                        r_st <= S_IDLE;
                    end
                end
                default: r_st <= S_IDLE;
            endcase
        end
    end

    assign i_in.ready        = (r_st == S_IDLE);
    assign o_out.valid       = r_ovalid;
    assign o_out.next_pc     = r_pc;
    assign o_out.top_index   = r_t;
    assign o_out.base_index  = r_b;
    assign o_out.top_value   = signed'(r_otop);
    assign o_out.halted      = (r_pc == '0);
    assign o_out.fault       = r_fault;

endmodule

`default_nettype wire

// ===== src/psm_checker.sv =====
// ----------------------------------------------------------------------------
// Port checker for the p-code stack machine
// Watches the channel ports and flags protocol or result slips.
// ----------------------------------------------------------------------------
`default_nettype none

module psm_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        in_valid,
    input wire logic        in_ready,
    input wire logic        out_valid,
    input wire logic        out_ready,
    input wire logic [10:0] next_pc,
    input wire logic        halted,
    input wire logic [1:0]  fault
);

    a_halt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (halted == (next_pc == 11'd0))) else $error("halted mismatch");

    a_fault: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> (fault != 2'd3)) else $error("bad fault code");

    a_excl: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid |-> !in_ready) else $error("input taken while result pending");

    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_valid && !out_ready |=> out_valid && $stable(next_pc))
        else $error("result dropped");

    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("second transfer taken while busy");

endmodule

bind pcode_stack_machine_step psm_checker u_chk (
    .i_clk    (i_clk),
    .i_rst_n  (i_rst_n),
    .in_valid (i_in.valid),
    .in_ready (i_in.ready),
    .out_valid(o_out.valid),
    .out_ready(o_out.ready),
    .next_pc  (o_out.next_pc),
    .halted   (o_out.halted),
    .fault    (o_out.fault)
);

`default_nettype wire

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// P-code stack machine step testbench
// Drives p-code instructions into the block over the input channel and checks
// every result against a predictor that keeps its own data stack, pc and frame
// pointers. Directed instructions come first, then random well-formed programs
// mixed with noise, under several idle and stall phases.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;

    typedef struct packed {
        logic [10:0]        next_pc;
        logic [8:0]         top_index;
        logic [8:0]         base_index;
        logic signed [31:0] top_value;
        logic               halted;
        logic [1:0]         fault;
    } t_step_result;

    logic i_clk;
    logic i_rst_n;
    psm_in_if  in_ch();
    psm_out_if out_ch();

    pcode_stack_machine_step dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_in   (in_ch.sink),
        .o_out  (out_ch.source)
    );

    logic [31:0]  mach_stack [psm_pkg::STACK_DEPTH];
    logic [10:0]  mach_pc;
    logic [63:0]  mach_base;
    logic [63:0]  mach_top;
    logic [1:0]   step_fault;
    t_step_result pending_results[$];
    int  send_idle_pct;
    int  recv_stall_pct;
    int  error_count = 0;
    int  quiet_cycles = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic bit in_range(longint a);
        return a >= 0 && a < psm_pkg::STACK_DEPTH;
    endfunction

    function automatic logic [31:0] rd_cell(longint a);
        if (!in_range(a)) begin
            step_fault = psm_pkg::F_RANGE;
            return 32'd0;
        end
        return mach_stack[a];
    endfunction

    function automatic void wr_cell(longint a, logic [31:0] v);
        if (!in_range(a)) begin
            step_fault = psm_pkg::F_RANGE;
            return;
        end
        mach_stack[a] = v;
    endfunction

    function automatic longint link_walk(longint start, int lv);
        longint b1;
        b1 = start;
        for (int i = 0; i < lv; i++) begin
            b1 = longint'($signed(rd_cell(b1)));
        end
        return b1;
    endfunction

    function automatic longint wrap_ptr(longint v);
        longint m;
        if (!in_range(v)) begin
            step_fault = psm_pkg::F_RANGE;
        end
        m = v % psm_pkg::STACK_DEPTH;
        if (m < 0) begin
            m += psm_pkg::STACK_DEPTH;
        end
        return m;
    endfunction

    function automatic t_step_result execute_step(psm_pkg::t_kind kind, logic [1:0] lv,
                                                  logic [10:0] arg);
        longint t, b, x, y, link;
        logic [10:0] p;
        logic [31:0] r;
        t_step_result res;
        t = mach_top;
        b = mach_base;
        p = mach_pc + 11'd1;
        step_fault = psm_pkg::F_NONE;
        r = '0;
        case (kind)
            psm_pkg::K_LIT: begin
                t++;
                wr_cell(t, {21'd0, arg});
            end
            psm_pkg::K_OPR: begin
                if (arg == psm_pkg::OP_RET) begin
                    t = b - 1;
                    p = 11'(rd_cell(b + 2));
                    b = longint'($signed(rd_cell(b + 1)));
                end else if (arg == psm_pkg::OP_NEG) begin
                    wr_cell(t, 32'd0 - rd_cell(t));
                end else if (arg == psm_pkg::OP_ODD) begin
                    x = longint'($signed(rd_cell(t)));
                    wr_cell(t, 32'(x % 2));
                end else if ((arg >= psm_pkg::OP_ADD && arg <= psm_pkg::OP_DIV)
                             || (arg >= psm_pkg::OP_EQL && arg <= psm_pkg::OP_GEQ)) begin
                    t--;
                    x = longint'($signed(rd_cell(t)));
                    y = longint'($signed(rd_cell(t + 1)));
                    case (arg)
                        psm_pkg::OP_ADD: r = 32'(x + y);
                        psm_pkg::OP_SUB: r = 32'(x - y);
                        psm_pkg::OP_MUL: r = 32'(x * y);
                        psm_pkg::OP_DIV: begin
                            if (y == 0) begin
                                if (step_fault == psm_pkg::F_NONE) begin
                                    step_fault = psm_pkg::F_DIV0;
                                end
                                r = 32'd0;
                            end else begin
                                r = 32'(x / y);
                            end
                        end
                        psm_pkg::OP_EQL: r = 32'(x == y);
                        psm_pkg::OP_NEQ: r = 32'(x != y);
                        psm_pkg::OP_LSS: r = 32'(x < y);
                        psm_pkg::OP_LEQ: r = 32'(x <= y);
                        psm_pkg::OP_GTR: r = 32'(x > y);
                        default: r = 32'(x >= y);
                    endcase
                    wr_cell(t, r);
                end
            end
            psm_pkg::K_LOD: begin
                link = link_walk(b, lv);
                t++;
                wr_cell(t, rd_cell(link + arg));
            end
            psm_pkg::K_STO: begin
                link = link_walk(b, lv);
                wr_cell(link + arg, rd_cell(t));
                t--;
            end
            psm_pkg::K_CAL: begin
                link = link_walk(b, lv);
                wr_cell(t + 1, 32'(link));
                wr_cell(t + 2, 32'(b));
                wr_cell(t + 3, {21'd0, p});
                b = t + 1;
                p = arg;
            end
            psm_pkg::K_INT: t += arg;
            psm_pkg::K_JMP: p = arg;
            default: begin
                if (rd_cell(t) == 32'd0) begin
                    p = arg;
                end
                t--;
            end
        endcase
        mach_top  = wrap_ptr(t);
        mach_base = wrap_ptr(b);
        mach_pc   = p;
        res.next_pc    = p;
        res.top_index  = mach_top[8:0];
        res.base_index = mach_base[8:0];
        res.top_value  = mach_stack[mach_top];
        res.halted     = (p == 11'd0);
        res.fault      = step_fault;
        return res;
    endfunction

    task automatic send_instr(psm_pkg::t_kind kind, logic [1:0] lv, logic [10:0] arg);
        while ($urandom_range(99) < send_idle_pct) begin
            in_ch.valid <= 1'b0;
            @(negedge i_clk);
        end
        in_ch.valid    <= 1'b1;
        in_ch.kind     <= kind;
        in_ch.level    <= lv;
        in_ch.argument <= arg;
        @(posedge i_clk);
        while (!in_ch.ready) begin
            @(posedge i_clk);
        end
        pending_results.push_back(execute_step(kind, lv, arg));
        @(negedge i_clk);
    endtask

    always @(negedge i_clk) begin
        out_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    always @(posedge i_clk) begin
        t_step_result want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (pending_results.size() == 0) begin
                $error("result transfer with no instruction outstanding");
                error_count++;
            end else begin
                want = pending_results.pop_front();
                if (out_ch.next_pc !== want.next_pc) begin
                    $error("next_pc expected %0d got %0d", want.next_pc, out_ch.next_pc);
                    error_count++;
                end
                if (out_ch.top_index !== want.top_index) begin
                    $error("top_index expected %0d got %0d", want.top_index,
                           out_ch.top_index);
                    error_count++;
                end
                if (out_ch.base_index !== want.base_index) begin
                    $error("base_index expected %0d got %0d", want.base_index,
                           out_ch.base_index);
                    error_count++;
                end
                if (out_ch.top_value !== want.top_value) begin
                    $error("top_value expected %0d got %0d", want.top_value,
                           out_ch.top_value);
                    error_count++;
                end
                if (out_ch.halted !== want.halted) begin
                    $error("halted expected %0d got %0d", want.halted, out_ch.halted);
                    error_count++;
                end
                if (out_ch.fault !== want.fault) begin
                    $error("fault expected %0d got %0d", want.fault, out_ch.fault);
                    error_count++;
                end
            end
        end
    end

    // The clearing pass after reset accepts nothing, so it gets extra room.
    always @(posedge i_clk) begin
        if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles > 20000) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    function automatic logic [10:0] rand_oper();
        return 11'($urandom_range(13));
    endfunction

    task automatic test_directed();
        send_instr(psm_pkg::K_LIT, 2'd0, 11'd2047);
        send_instr(psm_pkg::K_LIT, 2'd0, 11'd0);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_DIV);
        send_instr(psm_pkg::K_LIT, 2'd0, 11'd7);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_NEG);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_ODD);
        send_instr(psm_pkg::K_LIT, 2'd0, 11'd1);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_SUB);
        send_instr(psm_pkg::K_LIT, 2'd0, 11'd1);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_DIV);
        for (int op = psm_pkg::OP_ADD; op <= psm_pkg::OP_GEQ; op++) begin
            send_instr(psm_pkg::K_LIT, 2'd0, 11'($urandom_range(2047)));
            send_instr(psm_pkg::K_OPR, 2'd0, 11'(op));
        end
        send_instr(psm_pkg::K_OPR, 2'd0, 11'd2047);
        send_instr(psm_pkg::K_CAL, 2'd3, 11'd2047);
        send_instr(psm_pkg::K_INT, 2'd0, 11'd3);
        send_instr(psm_pkg::K_LOD, 2'd1, 11'd1);
        send_instr(psm_pkg::K_STO, 2'd2, 11'd2);
        send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_RET);
        send_instr(psm_pkg::K_JPC, 2'd0, 11'd0);
        send_instr(psm_pkg::K_JMP, 2'd0, 11'd0);
        send_instr(psm_pkg::K_INT, 2'd0, 11'd2047);
        send_instr(psm_pkg::K_STO, 2'd3, 11'd2047);
        send_instr(psm_pkg::K_JPC, 2'd0, 11'd5);
    endtask

    // Mostly procedure frames with pushes, arithmetic and stores, plus noise.
    task automatic test_random(int count);
        int sent;
        int pick;
        sent = 0;
        while (sent < count) begin
            pick = $urandom_range(99);
            if (pick < 70) begin
                send_instr(psm_pkg::K_CAL, 2'($urandom_range(3)),
                           11'($urandom_range(2047)));
                send_instr(psm_pkg::K_INT, 2'd0, 11'($urandom_range(3, 6)));
                send_instr(psm_pkg::K_LIT, 2'd0, 11'($urandom_range(2047)));
                send_instr(psm_pkg::K_LOD, 2'($urandom_range(3)), 11'($urandom_range(5)));
                send_instr(psm_pkg::K_OPR, 2'd0, rand_oper());
                send_instr(psm_pkg::K_STO, 2'($urandom_range(3)),
                           11'($urandom_range(3, 5)));
                send_instr(psm_pkg::K_LOD, 2'd0, 11'($urandom_range(3, 5)));
                send_instr(psm_pkg::K_JPC, 2'd0, 11'($urandom_range(2047)));
                send_instr(psm_pkg::K_OPR, 2'd0, psm_pkg::OP_RET);
                sent += 9;
            end else begin
                send_instr(psm_pkg::t_kind'($urandom_range(7)), 2'($urandom_range(3)),
                           ($urandom_range(1) != 0) ? rand_oper()
                                                    : 11'($urandom_range(2047)));
                sent++;
            end
        end
    endtask

    initial begin
        foreach (mach_stack[i]) begin
            mach_stack[i] = 32'd0;
        end
        mach_pc        = 11'd0;
        mach_base      = 64'd1;
        mach_top       = 64'd0;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        in_ch.valid    = 1'b0;
        in_ch.kind     = psm_pkg::K_LIT;
        in_ch.level    = 2'd0;
        in_ch.argument = 11'd0;
        i_rst_n        = 1'b0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        test_directed();
        test_random(330);
        send_idle_pct = 52;
        test_random(330);
        send_idle_pct  = 0;
        recv_stall_pct = 52;
        test_random(330);
        send_idle_pct  = 11;
        recv_stall_pct = 11;
        test_random(330);
        in_ch.valid    <= 1'b0;
        recv_stall_pct = 0;
        send_idle_pct  = 0;

        while (pending_results.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (50) @(posedge i_clk);
        if (error_count == 0 && pending_results.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end
endmodule
